>>> rtl/longest_nondecreasing_subsequence_unit_macros.svh
// assertion macros shared by the checker of the longest non-decreasing subsequence unit
// no dependencies; every macro takes the clock and the active-low reset explicitly
`ifndef LONGEST_NONDECREASING_SUBSEQUENCE_UNIT_MACROS_SVH
`define LONGEST_NONDECREASING_SUBSEQUENCE_UNIT_MACROS_SVH

// same-cycle implication, reset disables the check
`define LNDS_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lnds checker: same-cycle property failed");

// next-cycle implication, reset disables the check
`define LNDS_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lnds checker: next-cycle property failed");

`endif

>>> rtl/lnds_pkg.sv
// shared types and constants for the longest non-decreasing subsequence unit
// no dependencies
`default_nettype none

package lnds_pkg;

    localparam int VALUE_IN_W = 32;
    localparam int RUN_W      = 11;

    typedef struct packed {
        logic signed [VALUE_IN_W-1:0] value;
        logic                         start_req;
    } in_item_t;

    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             dropped;
    } out_item_t;

    // commands from the sequencer to the search datapath
    typedef struct packed {
        logic load;
        logic step;
    } search_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } lnds_state_t;

endpackage

`default_nettype wire

>>> rtl/lnds_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lnds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/lnds_search.sv
// binary search datapath: key register, lo/hi bounds, probe address and the shared comparator
// depends on lnds_pkg
`default_nettype none

module lnds_search #(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int LEN_W       = $clog2(MAX_LEN + 1),
    parameter int ADDR_W      = $clog2(MAX_LEN)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lnds_pkg::search_ctl_t               ctl,
    input  wire logic [lnds_pkg::VALUE_IN_W-1:0]     value,
    input  wire logic [LEN_W-1:0]                    len_init,
    input  wire logic [VALUE_WIDTH-1:0]              rd_data,
    output logic      [ADDR_W-1:0]                   rd_addr,
    output logic      [VALUE_WIDTH-1:0]              key,
    output logic      [LEN_W-1:0]                    pos,
    output logic                                     last
);

    localparam int InW = lnds_pkg::VALUE_IN_W;

    logic [VALUE_WIDTH-1:0] ext;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [LEN_W-1:0]       lo_reg, lo_next;
    logic [LEN_W-1:0]       hi_reg, hi_next;
    logic [ADDR_W-1:0]      mid_reg;
    logic [LEN_W-1:0]       span;
    logic [LEN_W-1:0]       mid_wide;
    logic                   greater;

    generate
        if (VALUE_WIDTH <= InW)
        begin : g_narrow
            assign ext = value[VALUE_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign ext = {{(VALUE_WIDTH-InW){value[InW-1]}}, value};
        end
    endgenerate

    // the one comparator: stored tail against the key, both in offset-binary order
    assign greater = rd_data > key_reg;

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctl.load)
        begin
            lo_next = '0;
            hi_next = len_init;
        end
        else if (ctl.step)
        begin
            if (greater)
            begin
                hi_next = LEN_W'(mid_reg);
            end
            else
            begin
                lo_next = LEN_W'(mid_reg) + LEN_W'(1);
            end
        end
    end

    assign span     = hi_next - lo_next;
    assign mid_wide = lo_next + (span >> 1);
    assign rd_addr  = mid_wide[ADDR_W-1:0];
    assign last     = (lo_next == hi_next);
    assign pos      = lo_reg;
    assign key      = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= '0;
            hi_reg  <= '0;
            mid_reg <= '0;
        end
        else
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_wide[ADDR_W-1:0];
        end
    end

    // sign bit flipped so unsigned compare follows signed order
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= {~ext[VALUE_WIDTH-1], ext[VALUE_WIDTH-2:0]};
        end
    end

endmodule

`default_nettype wire

>>> rtl/longest_nondecreasing_subsequence_unit.sv
// Longest non-decreasing subsequence unit (patience method). Each value binary-searches a
// sorted table of smallest tails held in one ram, probing one entry per cycle through a
// single comparator, then overwrites the first tail above it or appends. The search makes
// p probes, at most ceil(log2(L + 1)) for a table of L entries; the unit then waits in the
// finish state until the previous result has been taken, and only then accepts a new value;
// the ram's single read port sets the probe rate.
// Depends on lnds_pkg, lnds_ram and lnds_search.
`default_nettype none

module longest_nondecreasing_subsequence_unit #(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire lnds_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output lnds_pkg::out_item_t      result
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int RunW   = lnds_pkg::RUN_W;

    lnds_pkg::lnds_state_t state_reg, state_next;
    lnds_pkg::search_ctl_t ctl;
    lnds_pkg::out_item_t   result_reg;

    logic                   result_valid_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_init;
    logic [LEN_W-1:0]       len_after;
    logic [LEN_W-1:0]       pos;
    logic [ADDR_W-1:0]      rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic [VALUE_WIDTH-1:0] key;
    logic                   last;
    logic                   accept;
    logic                   slot_free;
    logic                   finish_load;
    logic                   grow;
    logic                   drop;

    assign accept    = item_valid && item_ready;
    assign slot_free = !result_valid_reg || result_ready;
    assign len_init  = item.start_req ? '0 : len_reg;
    assign grow      = (pos == len_reg) && (len_reg != LEN_W'(MAX_LEN));
    assign drop      = (pos == LEN_W'(MAX_LEN));
    assign len_after = grow ? len_reg + LEN_W'(1) : len_reg;

    lnds_search #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_WIDTH (VALUE_WIDTH),
        .LEN_W       (LEN_W),
        .ADDR_W      (ADDR_W)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .value    (item.value),
        .len_init (len_init),
        .rd_data  (rd_data),
        .rd_addr  (rd_addr),
        .key      (key),
        .pos      (pos),
        .last     (last)
    );

    lnds_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_tails (
        .clk     (clk),
        .wr_en   (finish_load && !drop),
        .wr_addr (pos[ADDR_W-1:0]),
        .wr_data (key),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lnds_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = last ? lnds_pkg::ST_FINISH : lnds_pkg::ST_SEARCH;
                end
            end
            lnds_pkg::ST_SEARCH:
            begin
                if (last)
                begin
                    state_next = lnds_pkg::ST_FINISH;
                end
            end
            lnds_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = lnds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lnds_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready  = 1'b0;
        ctl         = '0;
        finish_load = 1'b0;
        unique case (state_reg)
            lnds_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                ctl.load   = item_valid;
            end
            lnds_pkg::ST_SEARCH:
            begin
                ctl.step = 1'b1;
            end
            lnds_pkg::ST_FINISH:
            begin
                finish_load = slot_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lnds_pkg::ST_IDLE;
            len_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                len_reg <= len_init;
            end
            else if (finish_load)
            begin
                len_reg <= len_after;
            end
            if (finish_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // run length is reported modulo the output field width
    always_ff @(posedge clk)
    begin
        if (finish_load)
        begin
            result_reg.run_length <= RunW'(len_after);
            result_reg.dropped    <= drop;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> rtl/lnds_checker.sv
// port-level checker for the longest non-decreasing subsequence unit, bound to the top level
// depends on lnds_pkg and longest_nondecreasing_subsequence_unit_macros.svh
`default_nettype none

`include "longest_nondecreasing_subsequence_unit_macros.svh"

module lnds_checker #(
    parameter int MAX_LEN = 1024
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_ready,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire lnds_pkg::out_item_t result
);

    localparam int RunW = lnds_pkg::RUN_W;

    // a stalled result transfer keeps its payload
    `LNDS_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))

    // not ready again in the cycle after an input transfer
    `LNDS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && item_ready, !item_ready)

    // a fresh result coincides with the block going idle again
    `LNDS_ASSERT_NOW(a_idle_with_result, clk, rst_n, $rose(result_valid), item_ready)

    // a drop only happens with a full table
    `LNDS_ASSERT_NOW(a_drop_when_full, clk, rst_n, result_valid && result.dropped, result.run_length == RunW'(MAX_LEN))

endmodule

bind longest_nondecreasing_subsequence_unit lnds_checker #(
    .MAX_LEN (MAX_LEN)
) u_lnds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
